@@ src/multichannel_threshold_alarm_defines.svh @@
// Assertion macros for the multichannel threshold alarm.
// Included by files that check their own logic; expects clk_i and rst_ni in scope.
`ifndef MULTICHANNEL_THRESHOLD_ALARM_DEFINES_SVH
`define MULTICHANNEL_THRESHOLD_ALARM_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MTA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/mta_pkg.sv @@
// Shared types and constants for the multichannel threshold alarm.
// No dependencies; used by every other file of the block except the defines header.
`timescale 1ns / 1ps
`default_nettype none

package mta_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam int CMD_W      = 2;
  localparam int CHAN_W     = 3;
  localparam int EV_W       = 2;
  localparam int HYST_W     = 16;
  localparam int MASK_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  // Channels reachable through the channel field.
  localparam int CHAN_SPAN  = 2 ** CHAN_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE    = 2'd0,
    CMD_SET_UPPER = 2'd1,
    CMD_SET_LOWER = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_ABOVE  = 2'd1,
    ST_BELOW  = 2'd2
  } alarm_st_e;

  typedef enum logic [EV_W-1:0] {
    EV_NONE  = 2'd0,
    EV_UPPER = 2'd1,
    EV_LOWER = 2'd2,
    EV_CLEAR = 2'd3
  } event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALARM_EN = 2'd0,
    CFG_HYST     = 2'd1,
    CFG_MASK     = 2'd2
  } cfg_reg_e;

  // Per-channel update request from the evaluator to the channel store.
  typedef struct packed {
    logic      upper_we;
    logic      lower_we;
    logic      state_we;
    alarm_st_e state;
  } upd_t;

endpackage

`default_nettype wire

@@ src/mta_intf.sv @@
// Valid/ready channel interfaces for sample words and event words.
// Depends on mta_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mta_in_if #(
  parameter int SAMPLE_WIDTH = mta_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic [mta_pkg::CMD_W-1:0]      cmd;
  logic [mta_pkg::CHAN_W-1:0]     channel;
  logic signed [SAMPLE_WIDTH-1:0] value;

  modport source (output valid, cmd, channel, value, input ready);
  modport sink   (input valid, cmd, channel, value, output ready);
endinterface

interface mta_out_if #(
  parameter int SAMPLE_WIDTH = mta_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic [mta_pkg::EV_W-1:0]       event_res;
  logic [mta_pkg::CHAN_W-1:0]     event_channel;
  logic signed [SAMPLE_WIDTH-1:0] event_value;
  logic signed [SAMPLE_WIDTH-1:0] crossed_limit;

  modport source (output valid, event_res, event_channel, event_value, crossed_limit,
                  input ready);
  modport sink   (input valid, event_res, event_channel, event_value, crossed_limit,
                  output ready);
endinterface

`default_nettype wire

@@ src/mta_chan_regs.sv @@
// Per-channel limit, enable and alarm state registers with one read/write port.
// Depends on mta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mta_chan_regs #(
  parameter int NUM_CHANNELS = mta_pkg::NUM_CHANNELS_DEF,
  parameter int SAMPLE_WIDTH = mta_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [mta_pkg::CHAN_W-1:0]    chan_i,
  input  wire logic                          wr_en_i,
  input  wire mta_pkg::upd_t                 upd_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] wr_value_i,
  output logic                               chan_ok_o,
  output logic signed [SAMPLE_WIDTH-1:0]     upper_o,
  output logic signed [SAMPLE_WIDTH-1:0]     lower_o,
  output logic                               upper_en_o,
  output logic                               lower_en_o,
  output mta_pkg::alarm_st_e                 state_o
);

  // Only channels reachable by the channel field get storage.
  localparam int DEPTH = (NUM_CHANNELS < mta_pkg::CHAN_SPAN) ? NUM_CHANNELS
                                                            : mta_pkg::CHAN_SPAN;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [SAMPLE_WIDTH-1:0] upper_q [DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] lower_q [DEPTH];
  logic [DEPTH-1:0]               upper_en_q;
  logic [DEPTH-1:0]               lower_en_q;
  mta_pkg::alarm_st_e             state_q [DEPTH];

  logic [IDX_W-1:0] idx;
  logic             lim_nz;

  assign idx       = IDX_W'(chan_i);
  assign chan_ok_o = int'(chan_i) < DEPTH;
  assign lim_nz    = wr_value_i != '0;

  always_comb begin
    if (chan_ok_o) begin
      upper_o    = upper_q[idx];
      lower_o    = lower_q[idx];
      upper_en_o = upper_en_q[idx];
      lower_en_o = lower_en_q[idx];
      state_o    = state_q[idx];
    end else begin
      upper_o    = '0;
      lower_o    = '0;
      upper_en_o = 1'b0;
      lower_en_o = 1'b0;
      state_o    = mta_pkg::ST_NORMAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        upper_q[i] <= '0;
        lower_q[i] <= '0;
        state_q[i] <= mta_pkg::ST_NORMAL;
      end
      upper_en_q <= '0;
      lower_en_q <= '0;
    end else if (wr_en_i && chan_ok_o) begin
      if (upd_i.upper_we) begin
        upper_q[idx]    <= wr_value_i;
        upper_en_q[idx] <= lim_nz;
      end
      if (upd_i.lower_we) begin
        lower_q[idx]    <= wr_value_i;
        lower_en_q[idx] <= lim_nz;
      end
      if (upd_i.state_we) begin
        state_q[idx] <= upd_i.state;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/mta_eval.sv @@
// Window compare with hysteresis and limit-write decode for one word; pure combinational logic.
// Depends on mta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mta_eval #(
  parameter int SAMPLE_WIDTH = mta_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic [mta_pkg::CMD_W-1:0]      cmd_i,
  input  wire logic [mta_pkg::CHAN_W-1:0]     chan_i,
  input  wire logic                           chan_ok_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] value_i,
  input  wire logic                           alarm_en_i,
  input  wire logic [mta_pkg::HYST_W-1:0]     hyst_i,
  input  wire logic [mta_pkg::MASK_W-1:0]     mask_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] upper_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] lower_i,
  input  wire logic                           upper_en_i,
  input  wire logic                           lower_en_i,
  input  wire mta_pkg::alarm_st_e             state_i,
  output mta_pkg::event_e                     ev_o,
  output logic signed [SAMPLE_WIDTH-1:0]      ev_value_o,
  output logic signed [SAMPLE_WIDTH-1:0]      limit_o,
  output mta_pkg::upd_t                       upd_o
);

  // Wide enough that limit +/- hysteresis never wraps.
  localparam int CMP_W = SAMPLE_WIDTH + mta_pkg::HYST_W + 1;

  logic signed [CMP_W-1:0] val_w;
  logic signed [CMP_W-1:0] hy_w;
  logic signed [CMP_W-1:0] up_clr_w;
  logic signed [CMP_W-1:0] lo_clr_w;
  logic                    sample_ok;
  logic                    hit_up;
  logic                    hit_lo;
  logic                    clr_up;
  logic                    clr_lo;

  assign val_w    = CMP_W'(value_i);
  assign hy_w     = CMP_W'({1'b0, hyst_i});
  assign up_clr_w = CMP_W'(upper_i) - hy_w;
  assign lo_clr_w = CMP_W'(lower_i) + hy_w;

  assign sample_ok = chan_ok_i && alarm_en_i && mask_i[chan_i];
  assign hit_up    = upper_en_i && (value_i >= upper_i);
  assign hit_lo    = lower_en_i && (value_i <= lower_i);
  assign clr_up    = (state_i == mta_pkg::ST_ABOVE) && (val_w < up_clr_w);
  assign clr_lo    = (state_i == mta_pkg::ST_BELOW) && (val_w > lo_clr_w);

  always_comb begin
    ev_o       = mta_pkg::EV_NONE;
    ev_value_o = '0;
    limit_o    = '0;
    upd_o      = '{upper_we: 1'b0, lower_we: 1'b0, state_we: 1'b0,
                   state: mta_pkg::ST_NORMAL};
    case (mta_pkg::cmd_e'(cmd_i))
      mta_pkg::CMD_SET_UPPER: upd_o.upper_we = chan_ok_i;
      mta_pkg::CMD_SET_LOWER: upd_o.lower_we = chan_ok_i;
      mta_pkg::CMD_SAMPLE: begin
        if (sample_ok) begin
          if (hit_up) begin
            if (state_i != mta_pkg::ST_ABOVE) begin
              ev_o           = mta_pkg::EV_UPPER;
              ev_value_o     = value_i;
              limit_o        = upper_i;
              upd_o.state_we = 1'b1;
              upd_o.state    = mta_pkg::ST_ABOVE;
            end
          end else if (hit_lo) begin
            if (state_i != mta_pkg::ST_BELOW) begin
              ev_o           = mta_pkg::EV_LOWER;
              ev_value_o     = value_i;
              limit_o        = lower_i;
              upd_o.state_we = 1'b1;
              upd_o.state    = mta_pkg::ST_BELOW;
            end
          end else if (clr_up || clr_lo) begin
            ev_o           = mta_pkg::EV_CLEAR;
            ev_value_o     = value_i;
            upd_o.state_we = 1'b1;
            upd_o.state    = mta_pkg::ST_NORMAL;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ src/multichannel_threshold_alarm.sv @@
// Path: a word accepted into the input register is compared and its event word then loads
// the result register. Throughput: one word per cycle while out_o.ready does not stall it.
// Alarm state is written at the same edge as the result, so the next word sees it.
// Reset (async, active low): limits zero and disabled, all channels normal,
// alarm enable 1, hysteresis 0, all channels active, both pipeline stages empty.
`timescale 1ns / 1ps
`default_nettype none

`include "multichannel_threshold_alarm_defines.svh"

module multichannel_threshold_alarm #(
  parameter int NUM_CHANNELS = mta_pkg::NUM_CHANNELS_DEF,
  parameter int SAMPLE_WIDTH = mta_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [mta_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [mta_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  mta_in_if.sink                                 in_i,
  mta_out_if.source                              out_o
);

  // Configuration registers.
  logic                           alarm_en_q;
  logic [mta_pkg::HYST_W-1:0]     hyst_q;
  logic [mta_pkg::MASK_W-1:0]     mask_q;

  // Input stage.
  logic                           s1_valid_q;
  logic [mta_pkg::CMD_W-1:0]      s1_cmd_q;
  logic [mta_pkg::CHAN_W-1:0]     s1_chan_q;
  logic signed [SAMPLE_WIDTH-1:0] s1_value_q;

  // Result stage.
  logic                           out_valid_q;
  mta_pkg::event_e                out_ev_q;
  logic [mta_pkg::CHAN_W-1:0]     out_chan_q;
  logic signed [SAMPLE_WIDTH-1:0] out_value_q;
  logic signed [SAMPLE_WIDTH-1:0] out_limit_q;

  // Channel store read data and evaluator results.
  logic                           chan_ok;
  logic signed [SAMPLE_WIDTH-1:0] upper_lim;
  logic signed [SAMPLE_WIDTH-1:0] lower_lim;
  logic                           upper_en;
  logic                           lower_en;
  mta_pkg::alarm_st_e             cur_state;
  mta_pkg::event_e                ev;
  logic signed [SAMPLE_WIDTH-1:0] ev_value;
  logic signed [SAMPLE_WIDTH-1:0] ev_limit;
  mta_pkg::upd_t                  upd;

  logic in_acc;
  logic advance;

  // Advance the held word whenever the result register is free or being drained.
  assign advance  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_acc   = in_i.valid && in_i.ready;

  // Configuration writes; an unused index is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_en_q <= 1'b1;
      hyst_q     <= '0;
      mask_q     <= '1;
    end else if (cfg_we_i) begin
      case (mta_pkg::cfg_reg_e'(cfg_index_i))
        mta_pkg::CFG_ALARM_EN: alarm_en_q <= cfg_wdata_i[0];
        mta_pkg::CFG_HYST:     hyst_q     <= cfg_wdata_i[mta_pkg::HYST_W-1:0];
        mta_pkg::CFG_MASK:     mask_q     <= cfg_wdata_i[mta_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: capture on accept, empty once the word moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q   <= in_i.cmd;
      s1_chan_q  <= in_i.channel;
      s1_value_q <= in_i.value;
    end
  end

  mta_chan_regs #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .chan_i     (s1_chan_q),
    .wr_en_i    (advance),
    .upd_i      (upd),
    .wr_value_i (s1_value_q),
    .chan_ok_o  (chan_ok),
    .upper_o    (upper_lim),
    .lower_o    (lower_lim),
    .upper_en_o (upper_en),
    .lower_en_o (lower_en),
    .state_o    (cur_state)
  );

  mta_eval #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_eval (
    .cmd_i      (s1_cmd_q),
    .chan_i     (s1_chan_q),
    .chan_ok_i  (chan_ok),
    .value_i    (s1_value_q),
    .alarm_en_i (alarm_en_q),
    .hyst_i     (hyst_q),
    .mask_i     (mask_q),
    .upper_i    (upper_lim),
    .lower_i    (lower_lim),
    .upper_en_i (upper_en),
    .lower_en_i (lower_en),
    .state_i    (cur_state),
    .ev_o       (ev),
    .ev_value_o (ev_value),
    .limit_o    (ev_limit),
    .upd_o      (upd)
  );

  // Result register: load on advance, drop once the sink takes the word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_ev_q    <= ev;
      out_chan_q  <= s1_chan_q;
      out_value_q <= ev_value;
      out_limit_q <= ev_limit;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.event_res     = out_ev_q;
  assign out_o.event_channel = out_chan_q;
  assign out_o.event_value   = out_value_q;
  assign out_o.crossed_limit = out_limit_q;

  // Checks on the pipeline and the event encoding.
  `MTA_ASSERT_NEXT(a_accept_fills_stage, in_acc, s1_valid_q, "accepted word not held")
  `MTA_ASSERT_NOW(a_none_is_zero,
    out_valid_q && (out_ev_q == mta_pkg::EV_NONE),
    (out_value_q == '0) && (out_limit_q == '0), "empty event carries data")
  `MTA_ASSERT_NOW(a_upper_at_or_above,
    out_valid_q && (out_ev_q == mta_pkg::EV_UPPER),
    out_value_q >= out_limit_q, "upper alarm below its limit")
  `MTA_ASSERT_NOW(a_lower_at_or_below,
    out_valid_q && (out_ev_q == mta_pkg::EV_LOWER),
    out_value_q <= out_limit_q, "lower alarm above its limit")

endmodule

`default_nettype wire
